/* rtl/core/beam_code_nearest_delay_select_core_defines.svh */
// Assertion macros for the beam code selector core.
`ifndef BEAM_CODE_NEAREST_DELAY_SELECT_CORE_DEFINES_SVH
`define BEAM_CODE_NEAREST_DELAY_SELECT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at each rising clock edge outside reset.
`define BCNDS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bcnds assertion failed");

// Next-cycle implication.
`define BCNDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bcnds assertion failed");

`else

`define BCNDS_ASSERT_NOW(label, ante, cons)
`define BCNDS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/bcnds_pkg.sv */
// Package: constants, codes and types of the beam code selector core.
package bcnds_pkg;

   // Parameter defaults
   localparam int TABLE_DEPTH_DEF = 8192;
   localparam int ATTEN_BITS_DEF  = 6;

   // Field widths
   localparam int CARD_W   = 5;
   localparam int COUNT_W  = 14;
   localparam int POWER_W  = 24;
   localparam int DELAY_W  = 24;
   localparam int STEP_W   = 16;
   localparam int INDEX_W  = 13;
   localparam int ATTOUT_W = 6;
   localparam int CSR_IDX_W = 2;

   // Arithmetic constants
   localparam int DELAY_MAX     = 16777215;
   localparam int HALF_DB_SHIFT = 7;    // 0.5 dB = 128 in 1/256 dB
   localparam int ANTENNA_SPAN  = 15;
   localparam int CARD_FOLD     = 15;
   localparam int CARD_SHIFT    = 10;

   // Register reset values
   localparam int CARD_RST   = 0;
   localparam int COUNT_RST  = 8192;
   localparam int LOWEST_RST = 0;
   localparam int WINDOW_RST = 256000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CARD_INDEX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWEST_POWER = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_WINDOW = 2'd3;

   // Request function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_SCAN,
      ST_PREAD,
      ST_PCALC,
      ST_ATTEN,
      ST_OUT
   } state_type;

endpackage

/* rtl/core/beam_code_nearest_delay_select_core.sv */
// Beam code selector core: delay/power table and nearest-delay scan.
//
//  channel | ports                         | direction | accepted when
//  req     | req_valid/req_stall + fields  | in        | req_valid && !req_stall
//  rsp     | rsp_valid/rsp_stall + fields  | out       | rsp_valid && !rsp_stall
//  csr     | csr_write/csr_index/csr_data  | in        | csr_write
//
// A query word scans min(code_count, TABLE_DEPTH) table entries: the scan reads one
// entry per cycle through the single delay memory read port into one shared
// subtract/compare unit.
// Synchronous reset clears control state and CSRs, not payload registers or tables.
// A result held on rsp does not block acceptance of the next word; a finished query
// waits in its last state while the result register is still occupied.
`include "beam_code_nearest_delay_select_core_defines.svh"

module beam_code_nearest_delay_select_core #(
   parameter int TABLE_DEPTH = bcnds_pkg::TABLE_DEPTH_DEF,
   parameter int ATTEN_BITS  = bcnds_pkg::ATTEN_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [bcnds_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [bcnds_pkg::DELAY_W-1:0]         req_entry_delay,
   input  logic signed [bcnds_pkg::POWER_W-1:0]  req_entry_power,
   input  logic signed [bcnds_pkg::STEP_W-1:0]   req_step_delay,
   input  logic [bcnds_pkg::DELAY_W-1:0]         req_reference_delay,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bcnds_pkg::INDEX_W-1:0]         rsp_phase_code,
   output logic [bcnds_pkg::ATTOUT_W-1:0]        rsp_atten_code,
   output logic                                  rsp_matched,
   // configuration
   input  logic                                  csr_write,
   input  logic [bcnds_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bcnds_pkg::DELAY_W-1:0]         csr_data
);

   localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW        = $clog2(TABLE_DEPTH + 1);
   localparam int ATTEN_TOP = (1 << ATTEN_BITS) - 1;
   localparam int DW        = bcnds_pkg::DELAY_W;
   localparam int PW        = bcnds_pkg::POWER_W;
   localparam int QW        = DW - bcnds_pkg::HALF_DB_SHIFT;

   // configuration registers
   logic [bcnds_pkg::CARD_W-1:0]   card_ff;
   logic [bcnds_pkg::COUNT_W-1:0]  count_ff;
   logic signed [PW-1:0]           lowest_ff;
   logic [DW-1:0]                  window_ff;

   // sequencer
   bcnds_pkg::state_type           state_ff, state_in;
   logic signed [bcnds_pkg::STEP_W-1:0] step_ff, step_in;
   logic [DW-1:0]                  ref_ff, ref_in;
   logic signed [DW-1:0]           product_ff, product_in;
   logic [DW-1:0]                  needed_ff, needed_in;
   logic [CW-1:0]                  scan_limit_ff, scan_limit_in;
   logic [CW-1:0]                  scan_idx_ff, scan_idx_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [AW-1:0]                  rd_idx_ff, rd_idx_in;
   logic [DW-1:0]                  best_diff_ff, best_diff_in;
   logic [AW-1:0]                  best_code_ff, best_code_in;
   logic                           found_ff, found_in;
   logic signed [PW:0]             avail_ff, avail_in;
   logic [ATTEN_BITS-1:0]          atten_ff, atten_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bcnds_pkg::INDEX_W-1:0]  rsp_phase_ff, rsp_phase_in;
   logic [bcnds_pkg::ATTOUT_W-1:0] rsp_atten_ff, rsp_atten_in;
   logic                           rsp_matched_ff, rsp_matched_in;

   // tables
   logic [DW-1:0]                  delay_mem [TABLE_DEPTH];
   logic signed [PW-1:0]           power_mem [TABLE_DEPTH];
   logic [DW-1:0]                  delay_rdata_ff;
   logic signed [PW-1:0]           power_rdata_ff;

   logic                           req_take;
   logic                           load_we;
   logic [AW-1:0]                  load_addr;
   logic [bcnds_pkg::CARD_W-1:0]   antenna;
   logic signed [5:0]              mult_s;
   logic signed [bcnds_pkg::STEP_W:0] step_x;
   logic [bcnds_pkg::STEP_W:0]     mag;
   logic signed [DW+1:0]           sum_s;
   logic signed [DW:0]             diff_s;
   logic [DW-1:0]                  diff_abs;
   logic [DW-1:0]                  avail_m1;
   logic [QW-1:0]                  quot;
   logic                           slot_free;

   assign req_stall = (state_ff != bcnds_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_we   = req_take && (req_func == bcnds_pkg::FUNC_LOAD)
                      && (32'(req_entry_index) < TABLE_DEPTH);
   assign load_addr = AW'(req_entry_index);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         card_ff   <= bcnds_pkg::CARD_W'(bcnds_pkg::CARD_RST);
         count_ff  <= bcnds_pkg::COUNT_W'(bcnds_pkg::COUNT_RST);
         lowest_ff <= PW'(bcnds_pkg::LOWEST_RST);
         window_ff <= DW'(bcnds_pkg::WINDOW_RST);
      end else if (csr_write) begin
         case (csr_index)
            bcnds_pkg::CSR_CARD_INDEX:   card_ff   <= csr_data[bcnds_pkg::CARD_W-1:0];
            bcnds_pkg::CSR_CODE_COUNT:   count_ff  <= csr_data[bcnds_pkg::COUNT_W-1:0];
            bcnds_pkg::CSR_LOWEST_POWER: lowest_ff <= $signed(csr_data);
            bcnds_pkg::CSR_MATCH_WINDOW: window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- tables: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (load_we) begin
         delay_mem[load_addr] <= req_entry_delay;
      end
      delay_rdata_ff <= delay_mem[scan_idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         power_mem[load_addr] <= req_entry_power;
      end
      power_rdata_ff <= power_mem[best_code_ff];
   end

   // ---- datapath helpers
   always_comb begin
      // card number folds onto antenna position
      if (card_ff > bcnds_pkg::CARD_W'(bcnds_pkg::CARD_FOLD)) begin
         antenna = card_ff - bcnds_pkg::CARD_W'(bcnds_pkg::CARD_SHIFT);
      end else begin
         antenna = card_ff;
      end
      if (step_ff > 0) begin
         mult_s = $signed({1'b0, antenna});
      end else if (step_ff < 0) begin
         mult_s = 6'(bcnds_pkg::ANTENNA_SPAN) - $signed({1'b0, antenna});
      end else begin
         mult_s = '0;
      end
      step_x = {step_ff[bcnds_pkg::STEP_W-1], step_ff};
      mag    = step_x[bcnds_pkg::STEP_W] ? (bcnds_pkg::STEP_W+1)'(-step_x)
                                         : step_x;
      sum_s  = $signed({{2{product_ff[DW-1]}}, product_ff}) + $signed({2'b00, ref_ff});
      diff_s = $signed({1'b0, needed_ff}) - $signed({1'b0, delay_rdata_ff});
      diff_abs = diff_s[DW] ? DW'(-diff_s) : diff_s[DW-1:0];
      avail_m1 = DW'(avail_ff - (PW+1)'(1));
      quot     = avail_m1[DW-1:bcnds_pkg::HALF_DB_SHIFT];
   end

   // ---- sequencer: next state and next values
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      ref_in        = ref_ff;
      product_in    = product_ff;
      needed_in     = needed_ff;
      scan_limit_in = scan_limit_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_diff_in  = best_diff_ff;
      best_code_in  = best_code_ff;
      found_in      = found_ff;
      avail_in      = avail_ff;
      atten_in      = atten_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_phase_in  = rsp_phase_ff;
      rsp_atten_in  = rsp_atten_ff;
      rsp_matched_in = rsp_matched_ff;

      case (state_ff)
         bcnds_pkg::ST_IDLE: begin
            if (req_take && (req_func == bcnds_pkg::FUNC_QUERY)) begin
               step_in      = req_step_delay;
               ref_in       = req_reference_delay;
               scan_idx_in  = '0;
               best_diff_in = window_ff;
               best_code_in = '0;
               found_in     = 1'b0;
               if (32'(count_ff) > TABLE_DEPTH) begin
                  scan_limit_in = CW'(TABLE_DEPTH);
               end else begin
                  scan_limit_in = CW'(count_ff);
               end
               state_in = bcnds_pkg::ST_MUL;
            end
         end
         bcnds_pkg::ST_MUL: begin
            product_in = DW'(mult_s) * DW'($signed({1'b0, mag}));
            state_in   = bcnds_pkg::ST_SUM;
         end
         bcnds_pkg::ST_SUM: begin
            if (sum_s < 0) begin
               needed_in = '0;
            end else if (sum_s > (DW+2)'(bcnds_pkg::DELAY_MAX)) begin
               needed_in = DW'(bcnds_pkg::DELAY_MAX);
            end else begin
               needed_in = sum_s[DW-1:0];
            end
            state_in = bcnds_pkg::ST_SCAN;
         end
         bcnds_pkg::ST_SCAN: begin
            // compare the entry read last cycle; first strict minimum wins
            if (rd_valid_ff && (diff_abs < best_diff_ff)) begin
               best_diff_in = diff_abs;
               best_code_in = rd_idx_ff;
               found_in     = 1'b1;
            end
            if (scan_idx_ff < scan_limit_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_idx_ff[AW-1:0];
               scan_idx_in = scan_idx_ff + CW'(1);
            end else begin
               state_in = bcnds_pkg::ST_PREAD;
            end
         end
         bcnds_pkg::ST_PREAD: begin
            state_in = bcnds_pkg::ST_PCALC;
         end
         bcnds_pkg::ST_PCALC: begin
            avail_in = $signed({power_rdata_ff[PW-1], power_rdata_ff})
                       - $signed({lowest_ff[PW-1], lowest_ff});
            state_in = bcnds_pkg::ST_ATTEN;
         end
         bcnds_pkg::ST_ATTEN: begin
            if (avail_ff <= 0) begin
               atten_in = '0;
            end else if (quot > QW'(ATTEN_TOP)) begin
               atten_in = ATTEN_BITS'(ATTEN_TOP);
            end else begin
               atten_in = ATTEN_BITS'(quot);
            end
            state_in = bcnds_pkg::ST_OUT;
         end
         bcnds_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = found_ff;
               rsp_phase_in   = found_ff ? bcnds_pkg::INDEX_W'(best_code_ff) : '0;
               rsp_atten_in   = found_ff ? bcnds_pkg::ATTOUT_W'(atten_ff) : '0;
               state_in       = bcnds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcnds_pkg::ST_IDLE;
         end
      endcase
   end

   // ---- state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcnds_pkg::ST_IDLE;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   // ---- payload registers
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      ref_ff         <= ref_in;
      product_ff     <= product_in;
      needed_ff      <= needed_in;
      scan_limit_ff  <= scan_limit_in;
      rd_idx_ff      <= rd_idx_in;
      best_diff_ff   <= best_diff_in;
      best_code_ff   <= best_code_in;
      avail_ff       <= avail_in;
      atten_ff       <= atten_in;
      rsp_phase_ff   <= rsp_phase_in;
      rsp_atten_ff   <= rsp_atten_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phase_code = rsp_phase_ff;
   assign rsp_atten_code = rsp_atten_ff;
   assign rsp_matched    = rsp_matched_ff;

   // ---- assertions
   `BCNDS_ASSERT_NOW(a_rsp_from_out, $rose(rsp_valid), $past(state_ff) == bcnds_pkg::ST_OUT)
   `BCNDS_ASSERT_NOW(a_nomatch_zero, rsp_valid && !rsp_matched, (rsp_phase_code == '0) && (rsp_atten_code == '0))
   `BCNDS_ASSERT_NOW(a_scan_bound, state_ff == bcnds_pkg::ST_SCAN, scan_idx_ff <= scan_limit_ff)
   `BCNDS_ASSERT_NOW(a_found_window, (state_ff == bcnds_pkg::ST_SCAN) && found_ff, best_diff_ff < window_ff)
   `BCNDS_ASSERT_NEXT(a_query_leaves_idle, req_valid && !req_stall && (req_func == bcnds_pkg::FUNC_QUERY), state_ff == bcnds_pkg::ST_MUL)

endmodule
